// ===== rtl/core/wbce_pkg.sv =====
`default_nettype none
package wbce_pkg;

  localparam int unsigned LogitW = 16;
  localparam int unsigned LabelW = 16;
  localparam int unsigned LossW  = 32;
  localparam int unsigned GradW  = 16;
  localparam int unsigned TabW   = 17;
  localparam int unsigned TabRangeLog2 = 4;
  localparam int unsigned AddrW  = 3;

  localparam logic [AddrW-1:0] RegPosWeightAddr = 3'd0;

  localparam logic [63:0] Q30One = 64'd1 << 30;

  // fields that ride along the pipeline beside the table path
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [17:0] omz;
    logic signed [34:0] l23;
    logic        [16:0] neg;
    logic               neg_x;
    logic               last;
  } side_t;

  // shift-subtract divide for elaboration-time table building
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-step in q30, step = 16/entries
  function automatic logic [63:0] exp_step(input int unsigned entries);
    logic [63:0] s;
    logic [63:0] term;
    logic signed [63:0] e;
    s = udiv(64'd16 << 30, 64'(entries));
    term = Q30One;
    e = $signed(Q30One);
    for (int n = 1; n < 25; n++) begin
      term = udiv((term * s) >> 30, 64'(n));
      if (n % 2 == 1) e = e - $signed(term);
      else e = e + $signed(term);
    end
    if (e < 0) e = '0;
    return e;
  endfunction

  function automatic logic [63:0] u_at(input int unsigned k, input int unsigned entries);
    logic [63:0] e;
    logic [63:0] u;
    e = exp_step(entries);
    u = Q30One;
    for (int unsigned j = 0; j < k; j++) u = (u * e) >> 30;
    return u;
  endfunction

  // ln(1+u) via 2*atanh(u/(2+u)), q16
  function automatic logic [TabW-1:0] sp_entry(input int unsigned k, input int unsigned entries);
    logic [63:0] u;
    logic [63:0] w;
    logic [63:0] w2;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] v;
    u = u_at(k, entries);
    w = udiv(u << 30, 2 * Q30One + u);
    w2 = (w * w) >> 30;
    p = w;
    acc = '0;
    for (int m = 1; m < 40; m += 2) begin
      acc = acc + udiv(p, 64'(m));
      p = (p * w2) >> 30;
    end
    v = (2 * acc + 64'd8192) >> 14;
    return v[TabW-1:0];
  endfunction

  // 1/(1+e^a) = u/(1+u), q16
  function automatic logic [TabW-1:0] sg_entry(input int unsigned k, input int unsigned entries);
    logic [63:0] u;
    logic [63:0] v;
    u = u_at(k, entries);
    v = (udiv(u << 30, Q30One + u) + 64'd8192) >> 14;
    return v[TabW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wbce_lut.sv =====
`default_nettype none
module wbce_lut #(
  parameter int unsigned LOGIT_FRAC_BITS = 8,
  parameter int unsigned TABLE_ENTRIES   = 256,
  parameter int unsigned IW  = $clog2(TABLE_ENTRIES + 1),
  parameter int unsigned RSH = 4 + LOGIT_FRAC_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       en2_i,
  input  wire logic                       en3_i,
  input  wire logic [IW-1:0]              idx_i,
  input  wire logic [RSH-1:0]             rem_i,
  input  wire logic                       over_i,
  output      logic [wbce_pkg::TabW-1:0]  sp_o,
  output      logic [wbce_pkg::TabW-1:0]  sg_o
);
  import wbce_pkg::*;

  localparam int unsigned PmW = TabW + 2 + RSH;
  localparam logic signed [PmW-1:0] DenM1 = PmW'((64'd1 << RSH) - 64'd1);

  logic [TabW-1:0] sp_rom [TABLE_ENTRIES+1];
  logic [TabW-1:0] sg_rom [TABLE_ENTRIES+1];

  for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [TabW-1:0] SpV = sp_entry(k, TABLE_ENTRIES);
    localparam logic [TabW-1:0] SgV = sg_entry(k, TABLE_ENTRIES);
    assign sp_rom[k] = SpV;
    assign sg_rom[k] = SgV;
  end

  logic [IW-1:0] i0, i1;
  assign i0 = over_i ? '0 : idx_i;
  assign i1 = i0 + IW'(1);

  logic [TabW-1:0]          sp0_q, sg0_q;
  logic signed [TabW:0]     spd_q, sgd_q;
  logic [RSH-1:0]           rem_q;
  logic                     over_q;

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      sp0_q  <= sp_rom[i0];
      sg0_q  <= sg_rom[i0];
      spd_q  <= $signed({1'b0, sp_rom[i1]}) - $signed({1'b0, sp_rom[i0]});
      sgd_q  <= $signed({1'b0, sg_rom[i1]}) - $signed({1'b0, sg_rom[i0]});
      rem_q  <= rem_i;
      over_q <= over_i;
    end
  end

  // interpolation step truncates toward zero
  logic signed [PmW-1:0] sp_pm, sg_pm, sp_adj, sg_adj, sp_stp, sg_stp;
  logic [TabW-1:0] sp_d, sg_d;

  always_comb begin
    sp_pm  = PmW'(spd_q) * $signed({1'b0, rem_q});
    sg_pm  = PmW'(sgd_q) * $signed({1'b0, rem_q});
    sp_adj = (sp_pm < 0) ? sp_pm + DenM1 : sp_pm;
    sg_adj = (sg_pm < 0) ? sg_pm + DenM1 : sg_pm;
    sp_stp = sp_adj >>> RSH;
    sg_stp = sg_adj >>> RSH;
    sp_d   = over_q ? '0 : TabW'(PmW'(sp0_q) + sp_stp);
    sg_d   = over_q ? '0 : TabW'(PmW'(sg0_q) + sg_stp);
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      sp_o <= sp_d;
      sg_o <= sg_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wbce_mac.sv =====
`default_nettype none
module wbce_mac #(
  parameter int unsigned LOGIT_FRAC_BITS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             en4_i,
  input  wire logic                             en5_i,
  input  wire wbce_pkg::side_t                  side_i,
  input  wire logic [wbce_pkg::TabW-1:0]        sp_i,
  input  wire logic [wbce_pkg::TabW-1:0]        sg_i,
  output      logic signed [wbce_pkg::LossW-1:0] loss_o,
  output      logic signed [wbce_pkg::GradW-1:0] grad_o,
  output      logic                             sat_o,
  output      logic                             last_o
);
  import wbce_pkg::*;

  localparam int unsigned Sh = 39 - LOGIT_FRAC_BITS;

  // stage 4: products
  logic [29:0]        s16;
  logic [17:0]        sig16;
  logic signed [33:0] omzx_q;
  logic signed [17:0] omz_q;
  logic signed [63:0] pl_q, pg_q;
  logic               last4_q;

  always_comb begin
    s16   = 30'(sp_i) + (30'(side_i.neg) << (16 - LOGIT_FRAC_BITS));
    sig16 = side_i.neg_x ? 18'd65536 - 18'(sg_i) : 18'(sg_i);
  end

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      omzx_q  <= 34'(side_i.omz) * 34'(side_i.x);
      omz_q   <= side_i.omz;
      pl_q    <= 64'(side_i.l23) * $signed({34'd0, s16});
      pg_q    <= 64'(side_i.l23) * $signed({46'd0, sig16});
      last4_q <= side_i.last;
    end
  end

  // stage 5: sum, round half up, saturate
  logic signed [63:0] loss39, grad39, lr, gr;
  logic signed [LossW-1:0] loss_d;
  logic signed [GradW-1:0] grad_d;
  logic sat_d;

  always_comb begin
    loss39 = (64'(omzx_q) <<< (24 - LOGIT_FRAC_BITS)) + pl_q;
    grad39 = (64'(omz_q) <<< 24) - pg_q;
    lr = (loss39 + (64'sd1 <<< (Sh - 1))) >>> Sh;
    gr = (grad39 + (64'sd1 <<< (Sh - 1))) >>> Sh;
    sat_d = 1'b0;
    if (lr > 64'sd2147483647) begin
      loss_d = 32'sh7fffffff;
      sat_d = 1'b1;
    end else if (lr < -64'sd2147483648) begin
      loss_d = 32'sh80000000;
      sat_d = 1'b1;
    end else begin
      loss_d = lr[LossW-1:0];
    end
    if (gr > 64'sd32767) begin
      grad_d = 16'sh7fff;
      sat_d = 1'b1;
    end else if (gr < -64'sd32768) begin
      grad_d = 16'sh8000;
      sat_d = 1'b1;
    end else begin
      grad_d = gr[GradW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5_i) begin
      loss_o <= loss_d;
      grad_o <= grad_d;
      sat_o  <= sat_d;
      last_o <= last4_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/weighted_bce_logit_loss_grad_core.sv =====
// weighted binary cross-entropy with logits, loss and gradient per element
// input stream: s_axis_tdata = {label q2.14, logit}, s_axis_tlast marks the
// last item of a batch. output stream: m_axis_tdata = {gradient, loss},
// m_axis_tuser = saturation flag, m_axis_tlast copies the input's tlast.
// one item per cycle when m_axis_tready does not stall, in registered stages:
// stage 1 label/weight math and table address, stage 2 table read,
// stage 3 interpolation multiply, stage 4 weight products, stage 5 sum,
// rounding and saturation into the output register.
// each stage holds its item while the next one is full and held, so a stall on
// m_axis_tready fills the empty stages first and then drops s_axis_tready;
// no item is lost or repeated.
// the positive weight minus one is written over the apb port at offset 0
// and should only change while the pipeline is empty.
// reset empties the pipeline and sets the weight register to zero.
`default_nettype none
module weighted_bce_logit_loss_grad_core #(
  parameter int unsigned LOGIT_FRAC_BITS = 8,
  parameter int unsigned TABLE_ENTRIES   = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [wbce_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // logit, label_value
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,   // loss_out, gradient_out
  output      logic        m_axis_tuser,   // saturated
  output      logic        m_axis_tlast
);
  import wbce_pkg::*;

  localparam int unsigned IW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RSH = TabRangeLog2 + LOGIT_FRAC_BITS;
  localparam int unsigned PW  = RSH + IW + 17;
  localparam logic [31:0] Den = 32'd1 << RSH;

  // config register
  logic signed [15:0] pwm1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm1_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegPosWeightAddr) begin
      pwm1_q <= pwdata[15:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == RegPosWeightAddr) ? 32'(pwm1_q) : '0;

  // stage valids and advance enables
  logic [4:0] v_q;
  logic [5:1] en;
  always_comb begin
    en[5] = !v_q[4] || m_axis_tready;
    en[4] = !v_q[3] || en[5];
    en[3] = !v_q[2] || en[4];
    en[2] = !v_q[1] || en[3];
    en[1] = !v_q[0] || en[2];
  end
  assign s_axis_tready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[0] <= s_axis_tvalid;
      if (en[2]) v_q[1] <= v_q[0];
      if (en[3]) v_q[2] <= v_q[1];
      if (en[4]) v_q[3] <= v_q[2];
      if (en[5]) v_q[4] <= v_q[3];
    end
  end

  // stage 1
  logic signed [15:0] x_w, lab_w;
  logic signed [16:0] z15, ax;
  logic signed [32:0] wz;
  logic [16:0]        a_w;
  logic [PW-1:0]      pos, pos_sh;
  side_t              side_d;
  always_comb begin
    x_w    = s_axis_tdata[15:0];
    lab_w  = s_axis_tdata[31:16];
    z15    = 17'(lab_w) + 17'sd16384;
    wz     = 33'(pwm1_q) * 33'(z15);
    ax     = 17'(x_w);
    a_w    = x_w[15] ? 17'(-ax) : 17'(ax);
    pos    = PW'(a_w) * PW'(TABLE_ENTRIES);
    pos_sh = pos >> RSH;
    side_d.x     = x_w;
    side_d.omz   = 18'sd32768 - 18'(z15);
    side_d.l23   = 35'(wz) + 35'sd8388608;
    side_d.neg   = x_w[15] ? a_w : '0;
    side_d.neg_x = x_w[15];
    side_d.last  = s_axis_tlast;
  end

  side_t         s1_q, s2_q, s3_q;
  logic [IW-1:0] idx_q;
  logic [RSH-1:0] rem_q;
  logic          over_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q   <= side_d;
      idx_q  <= pos_sh[IW-1:0];
      rem_q  <= pos[RSH-1:0];
      over_q <= 32'(a_w) >= Den;
    end
    if (en[2]) s2_q <= s1_q;
    if (en[3]) s3_q <= s2_q;
  end

  logic [TabW-1:0] sp16, sg16;

  wbce_lut #(
    .LOGIT_FRAC_BITS(LOGIT_FRAC_BITS),
    .TABLE_ENTRIES  (TABLE_ENTRIES)
  ) u_lut (
    .clk_i (clk_i),
    .en2_i (en[2]),
    .en3_i (en[3]),
    .idx_i (idx_q),
    .rem_i (rem_q),
    .over_i(over_q),
    .sp_o  (sp16),
    .sg_o  (sg16)
  );

  logic signed [LossW-1:0] loss;
  logic signed [GradW-1:0] grad;

  wbce_mac #(
    .LOGIT_FRAC_BITS(LOGIT_FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .en4_i (en[4]),
    .en5_i (en[5]),
    .side_i(s3_q),
    .sp_i  (sp16),
    .sg_i  (sg16),
    .loss_o(loss),
    .grad_o(grad),
    .sat_o (m_axis_tuser),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tvalid = v_q[4];
  assign m_axis_tdata  = {grad, loss};

  // an empty output register never holds back the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a stalled first stage keeps its item
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !en[2] |=> v_q[0])
    else $error("stage 1 item lost under stall");

endmodule
`default_nettype wire

// ===== test/weighted_bce_logit_loss_grad_core_test.sv =====
`timescale 1ns / 100ps
module weighted_bce_logit_loss_grad_core_test;
  import wbce_pkg::*;

  localparam int unsigned Entries = 256;
  localparam int unsigned FracBits = 8;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic signed [31:0] loss;
    logic signed [15:0] grad;
    logic               sat;
    logic               last;
  } loss_grad_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // logit, label_value
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // loss_out, gradient_out
  logic m_axis_tuser;               // saturated
  logic m_axis_tlast;

  weighted_bce_logit_loss_grad_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  longint softplus_tab[Entries+1];
  longint sigmoid_tab[Entries+1];
  longint weight_m1;
  loss_grad_t expected_q[$];
  int failures;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  function automatic void build_curves();
    longint step, term, e, u, w, w2, p, acc;
    step = (longint'(16) << 30) / Entries;
    term = longint'(1) << 30;
    e = term;
    u = term;
    for (int n = 1; n < 25; n++) begin
      term = ((term * step) >>> 30) / n;
      if (n % 2 == 1) e -= term;
      else e += term;
    end
    if (e < 0) e = 0;
    for (int k = 0; k <= Entries; k++) begin
      w = (u << 30) / ((longint'(2) << 30) + u);
      w2 = (w * w) >>> 30;
      p = w;
      acc = 0;
      for (int m = 1; m < 40; m += 2) begin
        acc += p / m;
        p = (p * w2) >>> 30;
      end
      softplus_tab[k] = (2 * acc + 8192) >>> 14;
      sigmoid_tab[k] = (((u << 30) / ((longint'(1) << 30) + u)) + 8192) >>> 14;
      u = (u * e) >>> 30;
    end
  endfunction

  function automatic longint interp(bit use_sigmoid, longint a);
    longint den, pos, i, rem, lo, hi;
    den = longint'(16) << FracBits;
    if (a >= den) return 0;
    pos = a * Entries;
    i = pos / den;
    rem = pos - i * den;
    lo = use_sigmoid ? sigmoid_tab[i] : softplus_tab[i];
    hi = use_sigmoid ? sigmoid_tab[i+1] : softplus_tab[i+1];
    return lo + ((hi - lo) * rem) / den;
  endfunction

  function automatic loss_grad_t predict_loss_grad(logic signed [15:0] logit,
                                                   logic signed [15:0] label, logic last);
    longint x, z15, omz15, l23, a, negpart, sp, sg, sig, s16, loss39, grad39, lv, gv;
    loss_grad_t r;
    x = logit;
    z15 = longint'(label) + 16384;
    omz15 = 32768 - z15;
    l23 = (longint'(1) << 23) + weight_m1 * z15;
    a = x < 0 ? -x : x;
    negpart = x < 0 ? -x : 0;
    sp = interp(1'b0, a);
    sg = interp(1'b1, a);
    sig = x >= 0 ? sg : 65536 - sg;
    s16 = sp + negpart * (longint'(1) << (16 - FracBits));
    loss39 = omz15 * x * (longint'(1) << (24 - FracBits)) + l23 * s16;
    grad39 = omz15 * (longint'(1) << 24) - l23 * sig;
    // round half up then floor shift
    lv = (loss39 + (longint'(1) << (38 - FracBits))) >>> (39 - FracBits);
    gv = (grad39 + (longint'(1) << (38 - FracBits))) >>> (39 - FracBits);
    r.sat = 1'b0;
    if (lv > 64'sd2147483647) begin lv = 64'sd2147483647; r.sat = 1'b1; end
    if (lv < -64'sd2147483648) begin lv = -64'sd2147483648; r.sat = 1'b1; end
    if (gv > 32767) begin gv = 32767; r.sat = 1'b1; end
    if (gv < -32768) begin gv = -32768; r.sat = 1'b1; end
    r.loss = lv[31:0];
    r.grad = gv[15:0];
    r.last = last;
    return r;
  endfunction

  // check each result item against the oldest prediction
  always @(posedge clk_i) begin
    loss_grad_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("result item with no prediction waiting");
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== want.loss) begin
          $error("loss_out expected %0d actual %0d", want.loss,
                 $signed(m_axis_tdata[31:0]));
          failures++;
        end
        if (m_axis_tdata[47:32] !== want.grad) begin
          $error("gradient_out expected %0d actual %0d", want.grad,
                 $signed(m_axis_tdata[47:32]));
          failures++;
        end
        if (m_axis_tuser !== want.sat) begin
          $error("saturated expected %0b actual %0b", want.sat, m_axis_tuser);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out expected %0b actual %0b", want.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_item(logic [15:0] logit, logic [15:0] label, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {label, logit};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict_loss_grad(logit, label, last));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    // pipeline is five stages deep
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_weight(logic [15:0] w);
    write_reg(RegPosWeightAddr, {16'($urandom), w});
    weight_m1 = longint'($signed(w));
  endtask

  task automatic test_directed();
    logic [15:0] logits[12] = '{16'h8000, 16'h7fff, 16'h0000, 16'h1000, 16'hf000,
                                16'h0fff, 16'hf001, 16'h0001, 16'hffff, 16'h0100,
                                16'hff00, 16'h0080};
    logic [15:0] labels[6] = '{16'hc000, 16'h4000, 16'h0000, 16'h8000, 16'h7fff, 16'h2000};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (logits[i]) send_item(logits[i], labels[i % 2], i[0]);
    foreach (labels[i]) send_item(logits[i], labels[i], 1'b1);
    send_item(16'hffff, 16'hffff, 1'b0);
    drain();
    // no register exists at address 4, weight must stay
    write_reg(AddrW'(4), 32'h0000_1234);
    send_item(16'h0200, 16'h4000, 1'b0);
    drain();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct, logic [15:0] w);
    logic [15:0] x, lab;
    set_weight(w);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // mostly logits within the table range and hard labels
      x = ($urandom_range(9) < 7) ? 16'($signed($urandom_range(8192)) - 4096)
                                  : 16'($urandom);
      case ($urandom_range(9))
        0: lab = 16'($urandom);
        1: lab = 16'($signed($urandom_range(32768)) - 16384);
        default: lab = $urandom_range(1) ? 16'h4000 : 16'hc000;
      endcase
      send_item(x, lab, ($urandom_range(15) == 0));
      if (n == count / 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (n == count / 2 + 40) begin
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
      end
    end
    drain();
  endtask

  initial begin
    failures = 0;
    quiet_cycles = 0;
    weight_m1 = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    build_curves();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(320, 0, 0, 16'h0000);
    test_random(320, 50, 0, 16'hff00);
    test_random(320, 0, 50, 16'h7fff);
    test_random(320, 38, 38, 16'($urandom_range(32767)));
    test_random(320, 0, 0, 16'h8000);
    test_random(320, 38, 38, 16'h0100);
    if (failures == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
